/* hdl/utf8d_pkg.sv */
`default_nettype none

package utf8d_pkg;

	// Default depth of the result queue; two slots are kept free for one byte's results.
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_beat_t;

	typedef struct packed {
		logic [30:0] code_point;
		logic [2:0]  byte_length;
		logic        truncated;
		logic        last_of_run;
	} out_beat_t;

	// Results of one decoded byte, packed from slot 0 upward.
	typedef struct packed {
		logic [1:0] count;
		out_beat_t  slot0;
		out_beat_t  slot1;
	} dec_push_t;

	// Queue status seen by the input stage.
	typedef struct packed {
		logic room;
	} queue_stat_t;

endpackage

`default_nettype wire

/* hdl/utf8d_decode.sv */
`default_nettype none

module utf8d_decode (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 advance,
	input  utf8d_pkg::in_beat_t beat_s1,
	output utf8d_pkg::dec_push_t push
);

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_VAL   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_VAL  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_VAL  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_VAL  = 8'hF0;
	localparam logic [7:0] LEAD5_MASK = 8'hFC;
	localparam logic [7:0] LEAD5_VAL  = 8'hF8;
	localparam logic [7:0] LEAD6_MASK = 8'hFE;
	localparam logic [7:0] LEAD6_VAL  = 8'hFC;

	logic [30:0] pv_q, pv_n;
	logic [2:0]  el_q, el_n;
	logic [2:0]  gc_q, gc_n;
	logic        pend_q, pend_n;

	logic [7:0]  b;
	logic        eob;
	logic        cont;
	logic        have_a, have_b;
	logic [2:0]  lead_len;
	logic [4:0]  lead_bits;
	utf8d_pkg::out_beat_t res_a, res_b;

	assign b    = beat_s1.data_byte;
	assign eob  = beat_s1.end_of_buffer;
	assign cont = (b & CONT_MASK) == CONT_VAL;

	// Lead byte classification.
	always_comb begin
		lead_len  = 3'd0;
		lead_bits = 5'd0;
		if ((b & LEAD2_MASK) == LEAD2_VAL) begin
			lead_len  = 3'd2;
			lead_bits = b[4:0];
		end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
			lead_len  = 3'd3;
			lead_bits = {1'b0, b[3:0]};
		end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
			lead_len  = 3'd4;
			lead_bits = {2'b0, b[2:0]};
		end else if ((b & LEAD5_MASK) == LEAD5_VAL) begin
			lead_len  = 3'd5;
			lead_bits = {3'b0, b[1:0]};
		end else if ((b & LEAD6_MASK) == LEAD6_VAL) begin
			lead_len  = 3'd6;
			lead_bits = {4'b0, b[0]};
		end
	end

	// Result slot A: character finished or cut short by this byte.
	// Result slot B: the new character that this byte opens.
	always_comb begin
		pv_n   = pv_q;
		el_n   = el_q;
		gc_n   = gc_q;
		pend_n = pend_q;
		have_a = 1'b0;
		have_b = 1'b0;
		res_a  = '0;
		res_b  = '0;
		if (pend_q && cont) begin
			pv_n = {pv_q[24:0], b[5:0]};
			gc_n = gc_q + 3'd1;
			if (gc_n >= el_q) begin
				have_a = 1'b1;
				res_a  = '{code_point: pv_n, byte_length: gc_n, truncated: 1'b0,
					last_of_run: 1'b0};
				pend_n = 1'b0;
			end else if (eob) begin
				have_a = 1'b1;
				res_a  = '{code_point: pv_n, byte_length: gc_n, truncated: 1'b1,
					last_of_run: 1'b0};
				pend_n = 1'b0;
			end
		end else begin
			if (pend_q) begin
				have_a = 1'b1;
				res_a  = '{code_point: pv_q, byte_length: gc_q, truncated: 1'b1,
					last_of_run: 1'b0};
				pend_n = 1'b0;
			end
			if (!b[7]) begin
				have_b = 1'b1;
				res_b  = '{code_point: {24'd0, b[6:0]}, byte_length: 3'd1,
					truncated: 1'b0, last_of_run: 1'b0};
			end else if (lead_len != 3'd0) begin
				pv_n   = {26'd0, lead_bits};
				el_n   = lead_len;
				gc_n   = 3'd1;
				pend_n = 1'b1;
				if (eob) begin
					have_b = 1'b1;
					res_b  = '{code_point: {26'd0, lead_bits}, byte_length: 3'd1,
						truncated: 1'b1, last_of_run: 1'b0};
					pend_n = 1'b0;
				end
			end else begin
				// stray continuation or 0xFE/0xFF: pass through unsigned
				have_b = 1'b1;
				res_b  = '{code_point: {23'd0, b}, byte_length: 3'd1,
					truncated: 1'b0, last_of_run: 1'b0};
			end
		end
	end

	// Pack results from slot 0 and mark the last one.
	always_comb begin
		push = '0;
		if (advance) begin
			push.count = {1'b0, have_a} + {1'b0, have_b};
			if (have_a) begin
				push.slot0 = res_a;
				push.slot1 = res_b;
			end else begin
				push.slot0 = res_b;
			end
			push.slot0.last_of_run = (push.count == 2'd1);
			push.slot1.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= '0;
			el_q   <= '0;
			gc_q   <= '0;
			pend_q <= 1'b0;
		end else if (advance) begin
			pv_q   <= pv_n;
			el_q   <= el_n;
			gc_q   <= gc_n;
			pend_q <= pend_n;
		end
	end

	a_pend_short: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (gc_q >= 3'd1) && (gc_q < el_q) && (el_q <= 3'd6))
		else $error("character in progress with bad length bookkeeping");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("more than two results from one byte");

	a_idle_push: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |-> push.count == 2'd0)
		else $error("results pushed without an advancing byte");

endmodule

`default_nettype wire

/* hdl/utf8d_queue.sv */
`default_nettype none

module utf8d_queue #(
	parameter int Depth = utf8d_pkg::QUEUE_DEPTH
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  utf8d_pkg::dec_push_t   push,
	output utf8d_pkg::queue_stat_t stat,
	output logic                   char_valid,
	input  wire                    char_stall,
	output utf8d_pkg::out_beat_t   char_beat
);

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	utf8d_pkg::out_beat_t mem_q [Depth];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_1;
	logic [CW-1:0] count_q;
	logic          pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(Depth - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_ptr_1   = ptr_inc(wr_ptr_q);
	assign char_valid = count_q != '0;
	assign char_beat  = mem_q[rd_ptr_q];
	assign pop        = char_valid && !char_stall;
	// keep room for the worst case of two results from one byte
	assign stat.room  = count_q <= CW'(Depth - 2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.slot0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_1] <= push.slot1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			case (push.count)
				2'd1:    wr_ptr_q <= wr_ptr_1;
				2'd2:    wr_ptr_q <= ptr_inc(wr_ptr_1);
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(Depth))
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> stat.room)
		else $error("results pushed without room for two");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd0) && !pop |=> $stable(count_q))
		else $error("queue count moved with no push or pop");

endmodule

`default_nettype wire

/* hdl/utf8_stream_decoder.sv */
`default_nettype none

// Byte-serial decoder for a lenient UTF-8 stream with lead forms of one to six bytes.
// Feed one byte per beat on the byte channel; set end_of_buffer on the last byte to flush
// a character still in progress. Each decoded character leaves on the char channel with
// its code point, byte length and a truncated flag; a byte that breaks off a character
// produces the cut-short character, then its own beat if any, and last_of_run marks the
// final beat caused by each input byte. Stray bytes (0x80-0xBF outside a character,
// 0xFE, 0xFF) pass through as one-byte characters with their unsigned value. Timing:
// a byte is taken every cycle as long as the char side keeps up; the byte is held in
// the input register, is decoded in one pass against the character state, and its
// results are written into the result queue that feeds the char channel. The result queue
// (QueueDepth entries) advances a byte only when two slots are free, and the char channel
// drains one beat per cycle while char_stall is low, so a byte that yields two results
// takes one output beat for each.
module utf8_stream_decoder #(
	parameter int QueueDepth = utf8d_pkg::QUEUE_DEPTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  byte_valid,
	output logic                 byte_stall,
	input  utf8d_pkg::in_beat_t  byte_beat,
	output logic                 char_valid,
	input  wire                  char_stall,
	output utf8d_pkg::out_beat_t char_beat
);

	logic                   valid_s1;
	utf8d_pkg::in_beat_t    beat_s1;
	logic                   advance;
	utf8d_pkg::dec_push_t   push;
	utf8d_pkg::queue_stat_t stat;

	// Advance the held byte once the queue can absorb both possible results;
	// otherwise stall the byte channel and hold the input register.
	assign advance    = valid_s1 && stat.room;
	assign byte_stall = valid_s1 && !stat.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload register: capture on accept only.
	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			beat_s1 <= byte_beat;
		end
	end

	utf8d_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.beat_s1 (beat_s1),
		.push    (push)
	);

	utf8d_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.stat       (stat),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat)
	);

endmodule

`default_nettype wire
